// File: sv/tjp_pkg.sv
// shared types and constants for the three joint pid block
// no dependencies
`default_nettype none
package tjp_pkg;

    localparam int NUM_JOINTS = 3;
    localparam int JW = $clog2(NUM_JOINTS);

    localparam int CFG_IW = 3;
    localparam int CFG_DW = 31;
    localparam logic [CFG_IW-1:0] CFG_GAIN_PROP  = 3'd0;
    localparam logic [CFG_IW-1:0] CFG_GAIN_DERIV = 3'd1;
    localparam logic [CFG_IW-1:0] CFG_GAIN_INTEG = 3'd2;
    localparam logic [CFG_IW-1:0] CFG_ERR_BOUND  = 3'd3;
    localparam logic [CFG_IW-1:0] CFG_TQ_LIMIT   = 3'd4;
    localparam logic [CFG_IW-1:0] CFG_HALF_PER   = 3'd5;
    localparam logic [CFG_IW-1:0] CFG_REF_AMP    = 3'd6;

    // reciprocals for divide by 3 and by 125
    localparam logic [29:0] RECIP3   = 30'd357913942;  // ceil(2^30/3)
    localparam logic [15:0] RECIP125 = 16'd33555;      // ceil(2^22/125)
    localparam int NUM_DIGITS = 7;

    typedef struct packed {
        logic signed [15:0] angle_joint1;
        logic signed [15:0] angle_joint2;
        logic signed [15:0] angle_joint3;
    } t_in;

    typedef struct packed {
        logic signed [31:0] torque_joint1;
        logic signed [31:0] torque_joint2;
        logic signed [31:0] torque_joint3;
    } t_out;

    typedef struct packed {
        logic signed [15:0] prev_angle;
        logic signed [31:0] prev_velocity;
        logic signed [31:0] older_velocity;
        logic signed [16:0] prev_error;
        logic signed [47:0] error_integral;
    } t_ent;

    typedef enum logic [3:0] {
        S_IDLE, S_RD, S_LOAD, S_DIVA, S_DIVB, S_MULP, S_MULD, S_RAW,
        S_INTEG, S_MLO, S_MHI, S_SUM, S_DIG, S_TERM, S_FIN
    } t_state;

endpackage
`default_nettype wire

// File: sv/tjp_ram.sv
// generic single write port ram with registered read
// no dependencies
`default_nettype none
module tjp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

// File: sv/three_joint_pid_square_ref.sv
// three joint pid controller with square wave reference, top level
// depends on tjp_pkg and tjp_ram
//
// One item carries three joint angles and yields one item of three saturated
// torques. Joints are handled one after another by a single shared datapath;
// each joint passes through a state memory read, a divide by 3, the gain
// multiplies, a split 48x16 integral multiply and a 7 step divide by 125. After
// the last joint the result is loaded into the output register and the block
// returns to idle, where it can take the next item; a stalled result holds the
// block in its final state until the output register is free. Per joint state
// sits in a small ram with per-entry valid bits, so it reads as zero after reset
// with no clearing pass. The input stalls while an item is in work.
`default_nettype none
module three_joint_pid_square_ref (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_in_valid,
    output logic                                o_in_stall,
    input  wire tjp_pkg::t_in                   i_in_data,
    output logic                                o_out_valid,
    input  wire logic                           i_out_stall,
    output tjp_pkg::t_out                       o_out_data,
    input  wire logic                           i_cfg_we,
    input  wire logic [tjp_pkg::CFG_IW-1:0]     i_cfg_index,
    input  wire logic [tjp_pkg::CFG_DW-1:0]     i_cfg_data
);
    localparam int NJ = tjp_pkg::NUM_JOINTS;
    localparam int JW = tjp_pkg::JW;
    localparam int EW = $bits(tjp_pkg::t_ent);

    // configuration
    logic [15:0]        r_kp, r_kd, r_ki, r_half;
    logic [14:0]        r_ebound;
    logic [30:0]        r_tlimit;
    logic signed [15:0] r_amp;

    // tick state
    logic [15:0] r_phase;
    logic        r_high;

    tjp_pkg::t_state r_state, n_state;
    logic [JW-1:0]   r_j;
    logic [NJ-1:0]   r_vld;
    tjp_pkg::t_in    r_in;
    logic signed [15:0] r_ref;

    // datapath registers
    tjp_pkg::t_ent      r_ent;
    logic signed [15:0] r_ang;
    logic signed [33:0] r_sum;
    logic signed [16:0] r_err;
    logic               r_neg;
    logic [57:0]        r_p3;
    logic signed [31:0] r_vel;
    logic signed [33:0] r_pp;
    logic signed [48:0] r_pd;
    logic signed [45:0] r_raw;
    logic signed [47:0] r_integ;
    logic [39:0]        r_plo;
    logic signed [40:0] r_phi;
    logic               r_dneg;
    logic [55:0]        r_dmag;
    logic [55:0]        r_quo;
    logic [6:0]         r_rem;
    logic [2:0]         r_dcnt;
    logic signed [31:0] r_tq [NJ];
    logic               r_out_valid;
    tjp_pkg::t_out      r_out;

    // control
    logic          ram_we;
    logic [EW-1:0] ram_rdata;
    tjp_pkg::t_ent ram_wdata;
    logic          in_acc, out_free;

    assign in_acc   = i_in_valid && (r_state == tjp_pkg::S_IDLE);
    assign out_free = !r_out_valid || !i_out_stall;

    tjp_ram #(.WIDTH(EW), .DEPTH(NJ)) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_j),
        .i_wdata (ram_wdata),
        .i_raddr (r_j),
        .o_rdata (ram_rdata)
    );

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            tjp_pkg::S_IDLE:  if (i_in_valid) n_state = tjp_pkg::S_RD;
            tjp_pkg::S_RD:    n_state = tjp_pkg::S_LOAD;
            tjp_pkg::S_LOAD:  n_state = tjp_pkg::S_DIVA;
            tjp_pkg::S_DIVA:  n_state = tjp_pkg::S_DIVB;
            tjp_pkg::S_DIVB:  n_state = tjp_pkg::S_MULP;
            tjp_pkg::S_MULP:  n_state = tjp_pkg::S_MULD;
            tjp_pkg::S_MULD:  n_state = tjp_pkg::S_RAW;
            tjp_pkg::S_RAW:   n_state = tjp_pkg::S_INTEG;
            tjp_pkg::S_INTEG: n_state = tjp_pkg::S_MLO;
            tjp_pkg::S_MLO:   n_state = tjp_pkg::S_MHI;
            tjp_pkg::S_MHI:   n_state = tjp_pkg::S_SUM;
            tjp_pkg::S_SUM:   n_state = tjp_pkg::S_DIG;
            tjp_pkg::S_DIG: begin
                if (r_dcnt == 3'(tjp_pkg::NUM_DIGITS - 1)) n_state = tjp_pkg::S_TERM;
            end
            tjp_pkg::S_TERM: begin
                if (r_j == JW'(NJ - 1)) n_state = tjp_pkg::S_FIN;
                else n_state = tjp_pkg::S_RD;
            end
            tjp_pkg::S_FIN:   if (out_free) n_state = tjp_pkg::S_IDLE;
            default:          n_state = tjp_pkg::S_IDLE;
        endcase
    end

    // state outputs
    always_comb begin
        ram_we     = 1'b0;
        o_in_stall = 1'b1;
        case (r_state)
            tjp_pkg::S_IDLE:  o_in_stall = 1'b0;
            tjp_pkg::S_INTEG: ram_we = 1'b1;
            default: begin
                ram_we     = 1'b0;
                o_in_stall = 1'b1;
            end
        endcase
    end

    // datapath combinational pieces
    logic signed [15:0] ang_sel;
    tjp_pkg::t_ent      ent_rd;
    logic signed [16:0] dang;
    logic signed [33:0] d1000;
    logic [33:0]        sum_mag;
    logic [27:0]        q3;
    logic signed [49:0] rawdiff;
    logic [46:0]        raw_mag;
    logic [16:0]        err_mag;
    logic               clr_int;
    logic signed [49:0] acc;
    logic signed [47:0] integ_new;
    logic signed [64:0] prod_full;
    logic signed [56:0] prod_sh;
    logic [14:0]        dv;
    logic [30:0]        dq_prod;
    logic [7:0]         dq;
    logic [14:0]        dq125;
    logic [56:0]        quo_up;
    logic signed [58:0] term, tq;
    logic signed [31:0] tq_sat;
    logic [16:0]        phase_inc;
    logic [15:0]        hp;
    logic               high_new;

    always_comb begin
        case (r_j)
            JW'(0):  ang_sel = r_in.angle_joint1;
            JW'(1):  ang_sel = r_in.angle_joint2;
            default: ang_sel = r_in.angle_joint3;
        endcase
        ent_rd  = r_vld[r_j] ? tjp_pkg::t_ent'(ram_rdata) : '0;
        dang    = 17'(ang_sel) - 17'(ent_rd.prev_angle);
        // 1000 = 1024 - 16 - 8
        d1000   = (34'(dang) <<< 10) - (34'(dang) <<< 4) - (34'(dang) <<< 3);
        sum_mag = r_sum[33] ? 34'(-r_sum) : 34'(r_sum);
        q3      = r_p3[57:30];

        rawdiff = 50'(r_pp) - 50'(r_pd);
        raw_mag = r_raw[45] ? 47'(-48'(r_raw)) : 47'(r_raw);
        err_mag = r_err[16] ? 17'(-18'(r_err)) : 17'(r_err);
        clr_int = (raw_mag > 47'(r_tlimit)) || (err_mag > 17'(r_ebound));
        acc     = 50'(r_ent.error_integral) + 50'(r_err) + 50'(r_ent.prev_error);
        if (clr_int) begin
            integ_new = '0;
        end else if (acc[49:47] != {3{acc[47]}}) begin
            integ_new = acc[49] ? {1'b1, 47'd0} : {1'b0, {47{1'b1}}};
        end else begin
            integ_new = acc[47:0];
        end
        ram_wdata.prev_angle     = r_ang;
        ram_wdata.prev_velocity  = r_vel;
        ram_wdata.older_velocity = r_ent.prev_velocity;
        ram_wdata.prev_error     = r_err;
        ram_wdata.error_integral = integ_new;

        prod_full = (65'(r_phi) <<< 24) + 65'(r_plo);
        // floor by 256, then floor by 125 in digit steps
        prod_sh   = 57'(prod_full >>> 8);

        dv      = {r_rem, r_dmag[55:48]};
        dq_prod = 31'(dv) * 31'(tjp_pkg::RECIP125);
        dq      = dq_prod[29:22];
        dq125   = (15'(dq) << 7) - (15'(dq) << 1) - 15'(dq);

        quo_up  = 57'(r_quo) + 57'(r_rem != 7'd0);
        term    = r_dneg ? -59'(quo_up) : 59'(r_quo);
        tq      = 59'(r_raw) + term;
        if (tq[58:31] != {28{tq[31]}}) begin
            tq_sat = tq[58] ? {1'b1, 31'd0} : {1'b0, {31{1'b1}}};
        end else begin
            tq_sat = tq[31:0];
        end

        hp        = (r_half == 16'd0) ? 16'd1 : r_half;
        high_new  = (r_phase == 16'd0) ? !r_high : r_high;
        phase_inc = 17'(r_phase) + 17'd1;
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= tjp_pkg::S_IDLE;
            r_j         <= '0;
            r_vld       <= '0;
            r_phase     <= '0;
            r_high      <= 1'b0;
            r_out_valid <= 1'b0;
            r_dcnt      <= '0;
            r_kp        <= 16'd12800;
            r_kd        <= 16'd512;
            r_ki        <= 16'd0;
            r_ebound    <= 15'd205;
            r_tlimit    <= 31'd327680;
            r_half      <= 16'd3000;
            r_amp       <= 16'sd2130;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                case (i_cfg_index)
                    tjp_pkg::CFG_GAIN_PROP:  r_kp     <= i_cfg_data[15:0];
                    tjp_pkg::CFG_GAIN_DERIV: r_kd     <= i_cfg_data[15:0];
                    tjp_pkg::CFG_GAIN_INTEG: r_ki     <= i_cfg_data[15:0];
                    tjp_pkg::CFG_ERR_BOUND:  r_ebound <= i_cfg_data[14:0];
                    tjp_pkg::CFG_TQ_LIMIT:   r_tlimit <= i_cfg_data[30:0];
                    tjp_pkg::CFG_HALF_PER:   r_half   <= i_cfg_data[15:0];
                    tjp_pkg::CFG_REF_AMP:    r_amp    <= i_cfg_data[15:0];
                    default: ;
                endcase
            end
            if (in_acc) begin
                r_high  <= high_new;
                r_phase <= (phase_inc >= 17'(hp)) ? 16'd0 : phase_inc[15:0];
                r_j     <= '0;
            end
            if (r_state == tjp_pkg::S_INTEG) r_vld[r_j] <= 1'b1;
            if (r_state == tjp_pkg::S_SUM) r_dcnt <= '0;
            else if (r_state == tjp_pkg::S_DIG) r_dcnt <= r_dcnt + 3'd1;
            if (r_state == tjp_pkg::S_TERM && r_j != JW'(NJ - 1)) r_j <= r_j + JW'(1);
            if (r_state == tjp_pkg::S_FIN && out_free) r_out_valid <= 1'b1;
            else if (!i_out_stall) r_out_valid <= 1'b0;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_in  <= i_in_data;
            r_ref <= high_new ? r_amp : 16'sd0;
        end
        case (r_state)
            tjp_pkg::S_LOAD: begin
                r_ent <= ent_rd;
                r_ang <= ang_sel;
                r_err <= 17'(r_ref) - 17'(ang_sel);
                r_sum <= d1000 + 34'(ent_rd.prev_velocity) + 34'(ent_rd.older_velocity);
            end
            tjp_pkg::S_DIVA: begin
                r_neg <= r_sum[33];
                r_p3  <= 58'(sum_mag[28:0]) * 58'(tjp_pkg::RECIP3);
            end
            tjp_pkg::S_DIVB:  r_vel <= r_neg ? -32'(q3) : 32'(q3);
            tjp_pkg::S_MULP:  r_pp <= 34'($signed({1'b0, r_kp})) * 34'(r_err);
            tjp_pkg::S_MULD:  r_pd <= 49'($signed({1'b0, r_kd})) * 49'(r_vel);
            tjp_pkg::S_RAW:   r_raw <= 46'(rawdiff >>> 4);
            tjp_pkg::S_INTEG: r_integ <= integ_new;
            tjp_pkg::S_MLO:   r_plo <= 40'(r_ki) * 40'(r_integ[23:0]);
            tjp_pkg::S_MHI: begin
                r_phi <= 41'($signed({1'b0, r_ki})) * 41'($signed(r_integ[47:24]));
            end
            tjp_pkg::S_SUM: begin
                r_dneg <= prod_sh[56];
                r_dmag <= prod_sh[56] ? 56'(-prod_sh) : 56'(prod_sh);
                r_rem  <= '0;
                r_quo  <= '0;
            end
            tjp_pkg::S_DIG: begin
                r_quo  <= {r_quo[47:0], dq};
                r_rem  <= 7'(dv - dq125);
                r_dmag <= {r_dmag[47:0], 8'd0};
            end
            tjp_pkg::S_TERM:  r_tq[r_j] <= tq_sat;
            tjp_pkg::S_FIN: begin
                if (out_free) begin
                    r_out.torque_joint1 <= r_tq[0];
                    r_out.torque_joint2 <= r_tq[1];
                    r_out.torque_joint3 <= r_tq[2];
                end
            end
            default: ;
        endcase
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;
endmodule
`default_nettype wire

// File: sv/tjp_checker.sv
// port level checks for the three joint pid block
// depends on tjp_pkg; bound to three_joint_pid_square_ref
`default_nettype none
module tjp_checker (
    input wire logic          i_clk,
    input wire logic          i_rst_n,
    input wire logic          i_in_valid,
    input wire logic          o_in_stall,
    input wire logic          o_out_valid,
    input wire logic          i_out_stall,
    input wire tjp_pkg::t_out o_out_data
);
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_data))
        else $error("result item dropped or changed while stalled");

    a_busy_after_acc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("input not stalled after an item was taken");

    a_rise_needs_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(o_in_stall))
        else $error("result appeared with no item in work");

    a_no_instant: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> !$rose(o_out_valid))
        else $error("result came too soon after accept");
endmodule

bind three_joint_pid_square_ref tjp_checker u_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_data  (o_out_data)
);
`default_nettype wire

// File: bench/tjp_checker.sv
// torque predictor and checker for the three joint pid block
// depends on tjp_pkg; watches the input, output and register write ports
`timescale 1ns / 100ps
`default_nettype none
module tjp_scoreboard (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_in_valid,
    input  wire logic                       i_in_stall,
    input  wire tjp_pkg::t_in               i_in_data,
    input  wire logic                       i_out_valid,
    input  wire logic                       i_out_stall,
    input  wire tjp_pkg::t_out              i_out_data,
    input  wire logic                       i_cfg_we,
    input  wire logic [tjp_pkg::CFG_IW-1:0] i_cfg_index,
    input  wire logic [tjp_pkg::CFG_DW-1:0] i_cfg_data,
    output int                              o_fail_count,
    output int                              o_pending
);
    localparam int NJ = tjp_pkg::NUM_JOINTS;
    localparam longint INTEG_HI = 64'sh0000_7FFF_FFFF_FFFF;
    localparam longint INTEG_LO = -INTEG_HI - 1;

    logic [15:0]        kp, kd, ki, hper;
    logic [14:0]        ebound;
    logic [30:0]        tlimit;
    logic signed [15:0] ramp;
    logic [15:0]        phase;
    logic               ref_high;
    longint             last_ang [NJ];
    longint             vel1 [NJ];
    longint             vel2 [NJ];
    longint             last_err [NJ];
    longint             integ [NJ];
    tjp_pkg::t_out      torque_q[$];

    function automatic longint fdiv(longint a, longint b);
        longint q;
        q = a / b;
        if ((a % b) != 0 && a < 0) q = q - 1;
        return q;
    endfunction

    function automatic longint absv(longint a);
        return a < 0 ? -a : a;
    endfunction

    task automatic report(string what, longint got, longint want);
        $display("mismatch %s: got %0d expected %0d", what, got, want);
        o_fail_count++;
    endtask

    task automatic predict_torques(tjp_pkg::t_in it);
        longint        ang [NJ];
        longint        tq  [NJ];
        longint        hp, rv, err, vel, raw, acc;
        tjp_pkg::t_out r;
        ang[0] = it.angle_joint1;
        ang[1] = it.angle_joint2;
        ang[2] = it.angle_joint3;
        hp = (hper == 0) ? 1 : hper;
        if (phase == 0) ref_high = !ref_high;
        if (longint'(phase) + 1 >= hp) phase = 16'd0;
        else phase = phase + 16'd1;
        rv = ref_high ? longint'(ramp) : 0;
        for (int j = 0; j < NJ; j++) begin
            err = rv - ang[j];
            vel = (1000 * (ang[j] - last_ang[j]) + vel1[j] + vel2[j]) / 3;
            last_ang[j] = ang[j];
            vel2[j] = vel1[j];
            vel1[j] = vel;
            raw = fdiv(longint'(kp) * err - longint'(kd) * vel, 16);
            if (absv(raw) > longint'(tlimit) || absv(err) > longint'(ebound)) begin
                integ[j] = 0;
            end else begin
                acc = integ[j] + err + last_err[j];
                if (acc > INTEG_HI) acc = INTEG_HI;
                if (acc < INTEG_LO) acc = INTEG_LO;
                integ[j] = acc;
            end
            last_err[j] = err;
            tq[j] = raw + fdiv(longint'(ki) * integ[j], 32000);
            if (tq[j] > 64'sd2147483647) tq[j] = 64'sd2147483647;
            if (tq[j] < -64'sd2147483648) tq[j] = -64'sd2147483648;
        end
        r.torque_joint1 = tq[0][31:0];
        r.torque_joint2 = tq[1][31:0];
        r.torque_joint3 = tq[2][31:0];
        torque_q.push_back(r);
    endtask

    assign o_pending = torque_q.size();

    initial o_fail_count = 0;

    always @(posedge i_clk) begin
        tjp_pkg::t_out want;
        if (!i_rst_n) begin
            kp = 16'd12800; kd = 16'd512; ki = 16'd0; ebound = 15'd205;
            tlimit = 31'd327680; hper = 16'd3000; ramp = 16'sd2130;
            phase = 16'd0; ref_high = 1'b0;
            for (int j = 0; j < NJ; j++) begin
                last_ang[j] = 0; vel1[j] = 0; vel2[j] = 0;
                last_err[j] = 0; integ[j] = 0;
            end
            torque_q.delete();
        end else begin
            if (i_out_valid && !i_out_stall) begin
                if (torque_q.size() == 0) begin
                    $display("unexpected torque item");
                    o_fail_count++;
                end else begin
                    want = torque_q.pop_front();
                    if (i_out_data.torque_joint1 !== want.torque_joint1)
                        report("torque_joint1", i_out_data.torque_joint1, want.torque_joint1);
                    if (i_out_data.torque_joint2 !== want.torque_joint2)
                        report("torque_joint2", i_out_data.torque_joint2, want.torque_joint2);
                    if (i_out_data.torque_joint3 !== want.torque_joint3)
                        report("torque_joint3", i_out_data.torque_joint3, want.torque_joint3);
                end
            end
            if (i_in_valid && !i_in_stall) predict_torques(i_in_data);
            if (i_cfg_we) begin
                case (i_cfg_index)
                    tjp_pkg::CFG_GAIN_PROP:  kp = i_cfg_data[15:0];
                    tjp_pkg::CFG_GAIN_DERIV: kd = i_cfg_data[15:0];
                    tjp_pkg::CFG_GAIN_INTEG: ki = i_cfg_data[15:0];
                    tjp_pkg::CFG_ERR_BOUND:  ebound = i_cfg_data[14:0];
                    tjp_pkg::CFG_TQ_LIMIT:   tlimit = i_cfg_data[30:0];
                    tjp_pkg::CFG_HALF_PER:   hper = i_cfg_data[15:0];
                    tjp_pkg::CFG_REF_AMP:    ramp = i_cfg_data[15:0];
                    default: ;
                endcase
            end
        end
    end
endmodule
`default_nettype wire

// File: bench/tb_three_joint_pid_square_ref.sv
// testbench top for the three joint pid block: clock, reset, stimulus, verdict
// depends on tjp_pkg, three_joint_pid_square_ref and tjp_scoreboard
`timescale 1ns / 100ps
`default_nettype none
module tb_three_joint_pid_square_ref;
    localparam int WATCH_LIMIT = 20000;

    logic                       clk, rst_n;
    logic                       in_valid, in_stall, out_valid, out_stall;
    tjp_pkg::t_in               in_data;
    tjp_pkg::t_out              out_data;
    logic                       cfg_we;
    logic [tjp_pkg::CFG_IW-1:0] cfg_index;
    logic [tjp_pkg::CFG_DW-1:0] cfg_data;
    int                         fail_count, pending;
    int                         idle_cycles;
    logic                       rx_jitter, tx_jitter, hold_rx;

    three_joint_pid_square_ref uut (
        .i_clk(clk), .i_rst_n(rst_n),
        .i_in_valid(in_valid), .o_in_stall(in_stall), .i_in_data(in_data),
        .o_out_valid(out_valid), .i_out_stall(out_stall), .o_out_data(out_data),
        .i_cfg_we(cfg_we), .i_cfg_index(cfg_index), .i_cfg_data(cfg_data)
    );

    tjp_scoreboard chk (
        .i_clk(clk), .i_rst_n(rst_n),
        .i_in_valid(in_valid), .i_in_stall(in_stall), .i_in_data(in_data),
        .i_out_valid(out_valid), .i_out_stall(out_stall), .i_out_data(out_data),
        .i_cfg_we(cfg_we), .i_cfg_index(cfg_index), .i_cfg_data(cfg_data),
        .o_fail_count(fail_count), .o_pending(pending)
    );

    initial begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // receiver stall: random bursts, or a long hold while hold_rx is set
    initial begin
        int n;
        out_stall = 1'b0;
        forever begin
            @(posedge clk);
            if (hold_rx) begin
                out_stall <= 1'b1;
                repeat (400) @(posedge clk);
                out_stall <= 1'b0;
                wait (!hold_rx);
            end else if (rx_jitter && $urandom_range(0, 5) == 0) begin
                n = $urandom_range(1, 17);
                out_stall <= 1'b1;
                repeat (n) @(posedge clk);
                out_stall <= 1'b0;
            end
        end
    end

    // watchdog on accepted traffic
    always @(posedge clk) begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || !rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCH_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    // valid stays high after the accept so items can follow back to back
    task automatic send_angles(logic signed [15:0] a1, logic signed [15:0] a2,
                               logic signed [15:0] a3);
        int n;
        if (tx_jitter && $urandom_range(0, 4) == 0) begin
            n = $urandom_range(1, 17);
            in_valid <= 1'b0;
            repeat (n) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data <= '{a1, a2, a3};
        do @(posedge clk); while (in_stall);
    endtask

    task automatic drain;
        in_valid <= 1'b0;
        while (pending != 0) @(posedge clk);
        repeat (70) @(posedge clk);
    endtask

    task automatic write_reg(logic [tjp_pkg::CFG_IW-1:0] idx,
                             logic [tjp_pkg::CFG_DW-1:0] val);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    function automatic logic signed [15:0] near_angle(logic signed [15:0] base);
        return base + 16'($signed($urandom_range(0, 400)) - 200);
    endfunction

    task automatic random_phase(int count, logic wide);
        logic signed [15:0] b1, b2, b3;
        b1 = 16'($urandom); b2 = 16'($urandom); b3 = 16'($urandom);
        for (int i = 0; i < count; i++) begin
            if (wide || $urandom_range(0, 9) == 0) begin
                b1 = 16'($urandom); b2 = 16'($urandom); b3 = 16'($urandom);
                send_angles(b1, b2, b3);
            end else begin
                // small steps keep the integral path alive
                b1 = near_angle(b1 >>> 4); b2 = near_angle(b2 >>> 4);
                b3 = near_angle(b3 >>> 4);
                send_angles(b1, b2, b3);
            end
        end
    endtask

    initial begin
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_data = '0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        rx_jitter = 1'b0;
        tx_jitter = 1'b0;
        hold_rx = 1'b0;
        idle_cycles = 0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: extremes at reset settings
        send_angles(16'sh7FFF, 16'sh8000, 16'sh0000);
        send_angles(16'sh8000, 16'sh7FFF, 16'shFFFF);
        send_angles(16'sd0, 16'sd0, 16'sd0);
        send_angles(16'sd2130, 16'sd2100, 16'sd2200);
        send_angles(16'sd2130, 16'sd2130, 16'sd2130);
        drain();

        // directed: toggle each tick, big integral gain, unknown index ignored
        write_reg(tjp_pkg::CFG_HALF_PER, 31'd0);
        write_reg(tjp_pkg::CFG_GAIN_INTEG, 31'hFFFF);
        write_reg(tjp_pkg::CFG_ERR_BOUND, 31'h7FFF);
        write_reg(tjp_pkg::CFG_TQ_LIMIT, 31'h7FFF_FFFF);
        write_reg(tjp_pkg::CFG_REF_AMP, 31'h8000);
        write_reg(3'd7, 31'h1234);
        for (int i = 0; i < 8; i++) send_angles(16'sh7FFF, 16'sh8000, 16'sd100);
        drain();
        write_reg(tjp_pkg::CFG_GAIN_PROP, 31'hFFFF);
        write_reg(tjp_pkg::CFG_GAIN_DERIV, 31'hFFFF);
        write_reg(tjp_pkg::CFG_HALF_PER, 31'd1);
        write_reg(tjp_pkg::CFG_REF_AMP, 31'h7FFF);
        for (int i = 0; i < 6; i++) send_angles(16'sh8000, 16'sh7FFF, 16'sh8000);
        drain();
        // phase beyond a shortened half period wraps
        write_reg(tjp_pkg::CFG_HALF_PER, 31'd5);
        for (int i = 0; i < 3; i++) send_angles(16'sd0, 16'sd1, -16'sd1);
        drain();
        write_reg(tjp_pkg::CFG_HALF_PER, 31'd2);
        send_angles(16'sd7, 16'sd8, 16'sd9);
        drain();

        rx_jitter = 1'b1;
        tx_jitter = 1'b1;
        for (int p = 0; p < 6; p++) begin
            write_reg(tjp_pkg::CFG_GAIN_PROP,
                      (p == 0) ? 31'd0 : 31'($urandom_range(0, 65535)));
            write_reg(tjp_pkg::CFG_GAIN_DERIV,
                      (p == 1) ? 31'd0 : 31'($urandom_range(0, 2000)));
            write_reg(tjp_pkg::CFG_GAIN_INTEG,
                      (p == 2) ? 31'hFFFF : 31'($urandom_range(0, 65535)));
            write_reg(tjp_pkg::CFG_ERR_BOUND,
                      (p == 3) ? 31'd0 : 31'($urandom_range(0, 32767)));
            write_reg(tjp_pkg::CFG_TQ_LIMIT, (p == 4) ? 31'd0 : 31'($urandom));
            write_reg(tjp_pkg::CFG_HALF_PER, 31'($urandom_range(1, 20)));
            write_reg(tjp_pkg::CFG_REF_AMP, 31'($urandom_range(0, 65535)));
            random_phase(90, p == 5);
            if (p == 2) begin
                hold_rx = 1'b1;
                random_phase(10, 1'b0);
                hold_rx = 1'b0;
            end
            drain();
        end

        // final stretch with no idling
        rx_jitter = 1'b0;
        tx_jitter = 1'b0;
        random_phase(120, 1'b0);
        drain();

        if (fail_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end
endmodule
`default_nettype wire
